// ===== rtl/core/rgb_hue_rotation_unit_macros.svh =====
// Assertion macros shared by the hue rotation RTL.
`ifndef RGB_HUE_ROTATION_UNIT_MACROS_SVH
`define RGB_HUE_ROTATION_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define RHR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hue rotation assertion failed");

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define RHR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hue rotation assertion failed");

`endif

// ===== rtl/core/rhr_pkg.sv =====
// Package with constants, the sine table builder and angle folding for hue rotation.
package rhr_pkg;

    localparam int COEF_FRAC_BITS_DEF = 14;
    localparam int ANGLE_W            = 9;
    localparam int PX_W               = 8;
    localparam int SIN_W              = 31;
    localparam int SIN_ENTRIES        = 91;
    localparam int IDX_W              = 7;
    localparam int UPD_STAGES         = 4;
    localparam int TAYLOR_TERMS       = 10;

    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint PI_Q30  = 64'sd3373259426;

    // Taylor series denominators (2n)(2n+1) for n = 1 .. 10.
    localparam longint TAYLOR_DIV [TAYLOR_TERMS] = '{
        64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110,
        64'sd156, 64'sd210, 64'sd272, 64'sd342, 64'sd420
    };

    localparam logic [29:0] SQRT13_Q30 = 30'd619925131;
    localparam logic [31:0] RECIP3     = 32'hAAAA_AAAB;
    localparam logic [PX_W-1:0] PX_MAX = 8'hFF;

    localparam logic [ANGLE_W-1:0] DEG_90  = 9'd90;
    localparam logic [ANGLE_W-1:0] DEG_180 = 9'd180;
    localparam logic [ANGLE_W-1:0] DEG_270 = 9'd270;
    localparam logic [ANGLE_W-1:0] DEG_360 = 9'd360;

    typedef logic [SIN_W-1:0] t_sin_tab [SIN_ENTRIES];

    typedef struct packed {
        logic             neg;
        logic [IDX_W-1:0] idx;
    } t_fold;

    // Sine of k degrees (0..90) in Q1.30 from an eleven-term Taylor series.
    function automatic logic [SIN_W-1:0] sin_quarter(input int k);
        longint x;
        longint term;
        longint sum;
        longint t;
        int     n;
        x    = (longint'(k) * PI_Q30 + 64'sd90) / 64'sd180;
        term = x;
        sum  = x;
        for (n = 1; n <= TAYLOR_TERMS; n++) begin
            t    = term * x / Q30_ONE;
            t    = t * x / Q30_ONE;
            t    = t / TAYLOR_DIV[n - 1];
            term = -t;
            sum  = sum + term;
        end
        if (sum > Q30_ONE) begin
            sum = Q30_ONE;
        end
        if (sum < 0) begin
            sum = 0;
        end
        return sum[SIN_W-1:0];
    endfunction

    // Quarter-wave sine table, evaluated once at elaboration.
    function automatic t_sin_tab build_sin_tab();
        t_sin_tab tab;
        int       i;
        for (i = 0; i < SIN_ENTRIES; i++) begin
            tab[i] = sin_quarter(i);
        end
        return tab;
    endfunction

    // Maps an angle in 0..359 onto the quarter-wave table and a sign.
    function automatic t_fold fold_angle(input logic [ANGLE_W-1:0] k);
        t_fold f;
        if (k <= DEG_90) begin
            f.neg = 1'b0;
            f.idx = k[IDX_W-1:0];
        end else if (k <= DEG_180) begin
            f.neg = 1'b0;
            f.idx = IDX_W'(DEG_180 - k);
        end else if (k <= DEG_270) begin
            f.neg = 1'b1;
            f.idx = IDX_W'(k - DEG_180);
        end else begin
            f.neg = 1'b1;
            f.idx = IDX_W'(DEG_360 - k);
        end
        return f;
    endfunction

endpackage

// ===== rtl/core/rgb_hue_rotation_unit.sv =====
// Top level of the RGBA hue rotation unit: coefficient builder and pixel pipeline.
//
//  Channel   Direction  Handshake                  Payload
//  --------  ---------  -------------------------  -----------------------------------
//  pixel in  input      start, busy                i_red_in, i_green_in, i_blue_in,
//                                                  i_alpha_in
//  pixel out output     o_strobe (one cycle)       o_red_out, o_green_out, o_blue_out,
//                                                  o_alpha_out
//  config    input      i_cfg_valid, o_cfg_ready   i_hue_angle
//
// A pixel transaction is accepted at every edge with start high and busy low, so the
// pixel path sustains one pixel per clock. Each pixel passes through the input register,
// the product register and the result register, and is on the outputs while o_strobe is high.
// The receiver cannot stall; results flow on a fixed schedule.
// After reset, and after each config transaction, the four-stage coefficient builder
// runs; busy is high and o_cfg_ready is low while it runs.
// Reset is synchronous and active low and clears the hue angle to zero degrees.
module rgb_hue_rotation_unit
    import rhr_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               start,
    output logic               busy,
    input  logic [PX_W-1:0]    i_red_in,
    input  logic [PX_W-1:0]    i_green_in,
    input  logic [PX_W-1:0]    i_blue_in,
    input  logic [PX_W-1:0]    i_alpha_in,

    output logic               o_strobe,
    output logic [PX_W-1:0]    o_red_out,
    output logic [PX_W-1:0]    o_green_out,
    output logic [PX_W-1:0]    o_blue_out,
    output logic [PX_W-1:0]    o_alpha_out,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [ANGLE_W-1:0] i_hue_angle
);

    // Coefficients are signed with two integer bits; they stay within -1/3 .. +1.
    localparam int CW = COEF_FRAC_BITS + 2;
    // A product of a 9-bit signed pixel and a coefficient.
    localparam int PW = CW + PX_W + 1;
    // The sum of three products.
    localparam int AW = PW + 2;
    // Bits of the integer part of a non-negative sum.
    localparam int QW = AW - 1 - COEF_FRAC_BITS;
    // Rounding shift from Q30 down to the coefficient format.
    localparam int Sh = 30 - COEF_FRAC_BITS;
    localparam logic [32:0] Half = 33'(1) << (Sh - 1);

    localparam t_sin_tab SinTab = build_sin_tab();

    // ------------------------------------------------------------------------
    // Configuration register and coefficient builder
    // ------------------------------------------------------------------------
    // r_upd is a one-hot marker that walks through the four builder stages:
    // table lookup, multiplications, sums, and rounding into the coefficients.
    logic [ANGLE_W-1:0]    r_angle;
    logic [UPD_STAGES-1:0] r_upd;
    logic                  cfg_acc;

    assign busy        = |r_upd;
    assign o_cfg_ready = ~busy;
    assign cfg_acc     = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
            // Reset starts a build for angle zero so the matrix matches the register.
            r_upd   <= UPD_STAGES'(1);
        end else begin
            r_upd <= {r_upd[UPD_STAGES-2:0], cfg_acc};
            if (cfg_acc) begin
                r_angle <= i_hue_angle;
            end
        end
    end

    // Stage A: reduce the angle, fold sine and cosine onto the quarter-wave table.
    logic [ANGLE_W-1:0]   ang;
    logic [ANGLE_W:0]     ang_c_wide;
    logic [ANGLE_W-1:0]   ang_c;
    t_fold                fold_s;
    t_fold                fold_c;
    logic signed [31:0]   sin_pos;
    logic signed [31:0]   cos_pos;
    logic signed [31:0]   n_s;
    logic signed [31:0]   n_c;
    logic signed [31:0]   r_s;
    logic signed [31:0]   r_c;

    always_comb begin
        ang        = (r_angle >= DEG_360) ? (r_angle - DEG_360) : r_angle;
        ang_c_wide = {1'b0, ang} + {1'b0, DEG_90};
        if (ang_c_wide >= {1'b0, DEG_360}) begin
            ang_c = ANGLE_W'(ang_c_wide - {1'b0, DEG_360});
        end else begin
            ang_c = ang_c_wide[ANGLE_W-1:0];
        end
        fold_s  = fold_angle(ang);
        fold_c  = fold_angle(ang_c);
        sin_pos = $signed({1'b0, SinTab[fold_s.idx]});
        cos_pos = $signed({1'b0, SinTab[fold_c.idx]});
        n_s     = fold_s.neg ? -sin_pos : sin_pos;
        n_c     = fold_c.neg ? -cos_pos : cos_pos;
    end

    // Stage B: O = (1 - C) / 3 by reciprocal multiply, P = sqrt(1/3) * S toward zero.
    logic signed [32:0] o_diff;
    logic [31:0]        o_num;
    logic [63:0]        o_prod;
    logic [31:0]        s_negated;
    logic [30:0]        s_mag;
    logic [60:0]        p_prod;
    logic [29:0]        p_mag;
    logic [30:0]        n_o;
    logic signed [31:0] n_p;
    logic [30:0]        r_o;
    logic signed [31:0] r_p;

    always_comb begin
        o_diff    = $signed(33'(Q30_ONE)) - $signed({r_c[31], r_c});
        // 1 - C lies in 0 .. 2^31, so the low 32 bits hold it exactly.
        o_num     = o_diff[31:0];
        o_prod    = {32'b0, o_num} * {32'b0, RECIP3};
        n_o       = o_prod[63:33];
        s_negated = -r_s;
        s_mag     = r_s[31] ? s_negated[30:0] : r_s[30:0];
        p_prod    = {30'b0, s_mag} * {31'b0, SQRT13_Q30};
        p_mag     = p_prod[59:30];
        n_p       = r_s[31] ? -$signed({2'b0, p_mag}) : $signed({2'b0, p_mag});
    end

    // Stage C: the three distinct matrix entries in Q30.
    logic signed [32:0] n_d_raw;
    logic signed [32:0] n_lo_raw;
    logic signed [32:0] n_hi_raw;
    logic signed [32:0] r_d_raw;
    logic signed [32:0] r_lo_raw;
    logic signed [32:0] r_hi_raw;

    always_comb begin
        n_d_raw  = $signed({r_c[31], r_c}) + $signed({2'b0, r_o});
        n_lo_raw = $signed({2'b0, r_o}) - $signed({r_p[31], r_p});
        n_hi_raw = $signed({2'b0, r_o}) + $signed({r_p[31], r_p});
    end

    // Stage D: round half away from zero into the coefficient format.
    function automatic logic signed [CW-1:0] round_coef(input logic signed [32:0] v);
        logic [32:0] mag;
        logic [32:0] rnd;
        mag = v[32] ? 33'(-v) : 33'(v);
        rnd = (mag + Half) >> Sh;
        return CW'(v[32] ? -rnd : rnd);
    endfunction

    logic signed [CW-1:0] r_coef_d;
    logic signed [CW-1:0] r_coef_lo;
    logic signed [CW-1:0] r_coef_hi;

    always_ff @(posedge i_clk) begin
        if (r_upd[0]) begin
            r_s <= n_s;
            r_c <= n_c;
        end
        if (r_upd[1]) begin
            r_o <= n_o;
            r_p <= n_p;
        end
        if (r_upd[2]) begin
            r_d_raw  <= n_d_raw;
            r_lo_raw <= n_lo_raw;
            r_hi_raw <= n_hi_raw;
        end
        if (r_upd[3]) begin
            r_coef_d  <= round_coef(r_d_raw);
            r_coef_lo <= round_coef(r_lo_raw);
            r_coef_hi <= round_coef(r_hi_raw);
        end
    end

    // ------------------------------------------------------------------------
    // Pixel pipeline: input register, product register, result register
    // ------------------------------------------------------------------------
    logic            px_acc;
    logic            r_v1;
    logic            r_v2;
    logic            r_strobe;
    logic [PX_W-1:0] r_red;
    logic [PX_W-1:0] r_green;
    logic [PX_W-1:0] r_blue;
    logic [PX_W-1:0] r_alpha;
    logic [PX_W-1:0] r_alpha2;

    assign px_acc = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_v1     <= px_acc;
            r_v2     <= r_v1;
            r_strobe <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (px_acc) begin
            r_red   <= i_red_in;
            r_green <= i_green_in;
            r_blue  <= i_blue_in;
            r_alpha <= i_alpha_in;
        end
    end

    // The matrix is circulant: each row is the previous one rotated right.
    logic signed [PX_W:0]   px   [3];
    logic signed [CW-1:0]   coef [3][3];
    logic signed [PW-1:0]   r_prod [3][3];

    always_comb begin
        px[0]      = $signed({1'b0, r_red});
        px[1]      = $signed({1'b0, r_green});
        px[2]      = $signed({1'b0, r_blue});
        coef[0][0] = r_coef_d;
        coef[0][1] = r_coef_lo;
        coef[0][2] = r_coef_hi;
        coef[1][0] = r_coef_hi;
        coef[1][1] = r_coef_d;
        coef[1][2] = r_coef_lo;
        coef[2][0] = r_coef_lo;
        coef[2][1] = r_coef_hi;
        coef[2][2] = r_coef_d;
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[i][j] <= px[j] * coef[i][j];
                end
            end
            r_alpha2 <= r_alpha;
        end
    end

    // A negative sum always clamps to zero, whichever way it would be truncated,
    // so only a non-negative sum needs its fraction dropped.
    function automatic logic [PX_W-1:0] clamp_px(input logic signed [AW-1:0] acc);
        logic [QW-1:0] q;
        q = acc[AW-2:COEF_FRAC_BITS];
        if (acc[AW-1]) begin
            return '0;
        end else if (q > QW'(PX_MAX)) begin
            return PX_MAX;
        end else begin
            return q[PX_W-1:0];
        end
    endfunction

    logic signed [AW-1:0] acc [3];
    logic [PX_W-1:0]      r_out [3];
    logic [PX_W-1:0]      r_alpha_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i] = $signed({{2{r_prod[i][0][PW-1]}}, r_prod[i][0]})
                   + $signed({{2{r_prod[i][1][PW-1]}}, r_prod[i][1]})
                   + $signed({{2{r_prod[i][2][PW-1]}}, r_prod[i][2]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            for (int i = 0; i < 3; i++) begin
                r_out[i] <= clamp_px(acc[i]);
            end
            r_alpha_out <= r_alpha2;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_red_out   = r_out[0];
    assign o_green_out = r_out[1];
    assign o_blue_out  = r_out[2];
    assign o_alpha_out = r_alpha_out;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
`include "rgb_hue_rotation_unit_macros.svh"

    `RHR_ASSERT_IMP(a_upd_single, 1'b1, $onehot0(r_upd))
    `RHR_ASSERT_NXT(a_cfg_starts_build, cfg_acc, busy && r_upd[0])
    `RHR_ASSERT_NXT(a_coef_hold_idle, !busy,
        $stable(r_coef_d) && $stable(r_coef_lo) && $stable(r_coef_hi))
    `RHR_ASSERT_IMP(a_strobe_latency, o_strobe, $past(px_acc, 3))

endmodule
